FILE: src/mhi_pkg.sv
package mhi_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int COUNT_W   = 11;
   localparam int ENTRY_W   = KEY_W + PAYLOAD_W;

   typedef struct packed {
      logic load;       // capture an accepted item
      logic rd_parent;  // read the parent of the current hole
      logic move_down;  // copy the parent just read into the hole
      logic place;      // write the new entry into the hole
      logic load_rsp;   // capture the result into the output register
   } mhi_cmd_type;

   typedef struct packed {
      logic full;
      logic hole_zero;
      logic new_less;
   } mhi_sts_type;

endpackage

FILE: src/mhi_if.sv
interface mhi_req_if
   import mhi_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic signed [KEY_W-1:0]     key;
   logic        [PAYLOAD_W-1:0] payload;

   modport source (output valid, output key, output payload, input ready);
   modport sink   (input valid, input key, input payload, output ready);
endinterface

interface mhi_rsp_if
   import mhi_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic signed [KEY_W-1:0]     min_key;
   logic        [PAYLOAD_W-1:0] min_payload;
   logic        [COUNT_W-1:0]   entry_count;
   logic                        dropped;

   modport source (output valid, output min_key, output min_payload,
                   output entry_count, output dropped, input ready);
   modport sink   (input valid, input min_key, input min_payload,
                   input entry_count, input dropped, output ready);
endinterface

FILE: src/min_heap_insert.sv
// Channel   Direction  Transfer carries
// req_ch    in         key (signed 32), payload (32)
// rsp_ch    out        min_key (signed 32), min_payload (32), entry_count (11), dropped
//
// Each level that an insert rises costs a read of the parent and a compare that moves
// the parent down into the hole; the entry is placed once the hole is at the root or a
// parent stops it. An insert into a full heap is dropped without any write.
// Reset clears fill level, FSM state and rsp valid; heap memory is not cleared or swept.
// A result waiting on rsp_ch does not stop the next req_ch transfer; the block holds
// the following result until the output register has been taken.
module min_heap_insert
   import mhi_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   mhi_req_if.sink   req_ch,
   mhi_rsp_if.source rsp_ch
);

   mhi_cmd_type cmd;
   mhi_sts_type sts;

   mhi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mhi_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_key         (req_ch.key),
      .req_payload     (req_ch.payload),
      .rsp_min_key     (rsp_ch.min_key),
      .rsp_min_payload (rsp_ch.min_payload),
      .rsp_entry_count (rsp_ch.entry_count),
      .rsp_dropped     (rsp_ch.dropped)
   );

endmodule

FILE: src/mhi_datapath.sv
module mhi_datapath
   import mhi_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mhi_cmd_type                 cmd,
   output mhi_sts_type                 sts,
   input  logic signed [KEY_W-1:0]     req_key,
   input  logic        [PAYLOAD_W-1:0] req_payload,
   output logic signed [KEY_W-1:0]     rsp_min_key,
   output logic        [PAYLOAD_W-1:0] rsp_min_payload,
   output logic        [COUNT_W-1:0]   rsp_entry_count,
   output logic                        rsp_dropped
);

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);

   logic [ENTRY_W-1:0]   heap_mem [CAPACITY];
   logic [ENTRY_W-1:0]   rd_data_ff;

   logic [FW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        hole_ff, hole_in;
   logic [AW-1:0]        parent;
   logic signed [KEY_W-1:0]     new_key_ff;
   logic        [PAYLOAD_W-1:0] new_payload_ff;
   logic                 drop_ff;
   logic signed [KEY_W-1:0]     root_key_ff;
   logic        [PAYLOAD_W-1:0] root_payload_ff;

   logic signed [KEY_W-1:0]     rsp_key_ff;
   logic        [PAYLOAD_W-1:0] rsp_payload_ff;
   logic        [COUNT_W-1:0]   rsp_count_ff;
   logic                        rsp_drop_ff;

   logic [FW+COUNT_W-1:0] fill_ext;
   logic                  wr_en;
   logic [ENTRY_W-1:0]    wr_data;
   logic signed [KEY_W-1:0] parent_key;

   assign parent     = (hole_ff - AW'(1)) >> 1;
   assign parent_key = rd_data_ff[ENTRY_W-1 -: KEY_W];
   assign fill_ext   = {{COUNT_W{1'b0}}, fill_ff};

   assign sts.full      = (fill_ff == FW'(CAPACITY));
   assign sts.hole_zero = (hole_ff == '0);
   assign sts.new_less  = (new_key_ff < parent_key);

   assign wr_en   = cmd.move_down | cmd.place;
   assign wr_data = cmd.move_down ? rd_data_ff : {new_key_ff, new_payload_ff};

   always_comb begin
      fill_in = fill_ff;
      hole_in = hole_ff;
      if (cmd.load) begin
         hole_in = fill_ff[AW-1:0];
      end else if (cmd.move_down) begin
         hole_in = parent;
      end
      if (cmd.place) begin
         fill_in = fill_ff + FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      if (cmd.load) begin
         new_key_ff     <= req_key;
         new_payload_ff <= req_payload;
         drop_ff        <= sts.full;
      end
      if (cmd.place && sts.hole_zero) begin
         root_key_ff     <= new_key_ff;
         root_payload_ff <= new_payload_ff;
      end
      if (cmd.load_rsp) begin
         rsp_key_ff     <= root_key_ff;
         rsp_payload_ff <= root_payload_ff;
         rsp_count_ff   <= fill_ext[COUNT_W-1:0];
         rsp_drop_ff    <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[hole_ff] <= wr_data;
      end
      if (cmd.rd_parent) begin
         rd_data_ff <= heap_mem[parent];
      end
   end

   assign rsp_min_key     = rsp_key_ff;
   assign rsp_min_payload = rsp_payload_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_dropped     = rsp_drop_ff;

   a_place_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> fill_ff == $past(fill_ff) + FW'(1))
      else $error("fill level did not advance after an insert");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && drop_ff) |-> fill_ff == FW'(CAPACITY))
      else $error("dropped insert reported while the heap had room");

   a_move_not_root: assert property (@(posedge clock) disable iff (reset)
      cmd.move_down |-> hole_ff != '0)
      else $error("parent moved down into the root slot");

endmodule

FILE: src/mhi_ctrl.sv
module mhi_ctrl
   import mhi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  mhi_sts_type sts,
   output mhi_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_CMP    = 4'b0100,
      ST_FINISH = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.full ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            if (sts.hole_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sts.new_less) begin
               cmd.move_down = 1'b1;
               state_in      = ST_READ;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The result waits here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before its transfer");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff != ST_IDLE)
      else $error("controller idle straight after taking an item");

   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_parent |=> state_ff == ST_CMP)
      else $error("parent read not followed by a compare");

endmodule
